/* hw/rtl/teq_pkg.sv */
// types, constants and codes shared by the timed event queue modules
`timescale 1ns / 1ps
package teq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W      = 64;
    localparam int DELAY_W     = 48;
    localparam int TAG_W       = 16;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_CANCEL = 2'd1,
        OP_POP    = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_FULL        = 3'd1,
        ST_EMPTY       = 3'd2,
        ST_LIMIT       = 3'd3,
        ST_NOT_PENDING = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ENQ_TEST,
        S_ENQ_RD1,
        S_ENQ_RD2,
        S_RM_RD,
        S_RM_CHK,
        S_POP_RD1,
        S_POP_RD2,
        S_POP_TAIL,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH,
        DP_SET_STATUS,
        DP_INS_ALLOC,
        DP_CANCEL_START,
        DP_HEAD_READ,
        DP_ENQ_READ_ORD,
        DP_ENQ_READ_DUE,
        DP_ENQ_SHIFT,
        DP_ENQ_PUT,
        DP_RM_READ,
        DP_RM_CHECK,
        DP_RM_END,
        DP_POP_READ,
        DP_POP_ACCEPT,
        DP_REARM
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status code;
        logic    free_slot;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic full;
        logic handle_busy;
        logic empty;
        logic pos_zero;
        logic pos_at_count;
        logic enq_stop;
        logic beyond;
        logic slot_periodic;
    } t_dp_sts;

endpackage

/* hw/rtl/teq_datapath.sv */
// datapath of the timed event queue: time registers, slot flags and memories
`timescale 1ns / 1ps
module teq_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  teq_pkg::t_dp_cmd              i_cmd,
    output teq_pkg::t_dp_sts              o_sts,
    input  logic [teq_pkg::OP_W-1:0]      i_op,
    input  logic [teq_pkg::DELAY_W-1:0]   i_wait_ns,
    input  logic [teq_pkg::TAG_W-1:0]     i_event_tag,
    input  logic                          i_periodic,
    input  logic [teq_pkg::SLOT_W-1:0]    i_cancel_handle,
    input  logic [teq_pkg::DELAY_W-1:0]   i_window_ns,
    input  logic                          i_new_run,
    output logic [teq_pkg::STATUS_W-1:0]  o_status,
    output logic [teq_pkg::SLOT_W-1:0]    o_slot_handle,
    output logic [teq_pkg::TAG_W-1:0]     o_delivered_tag,
    output logic [teq_pkg::TIME_W-1:0]    o_current_time
);
    import teq_pkg::*;

    logic [OP_W-1:0]        r_op;
    logic [DELAY_W-1:0]     r_delay;
    logic [TAG_W-1:0]       r_in_tag;
    logic                   r_in_per;
    logic [SLOT_W-1:0]      r_in_handle;
    logic [DELAY_W-1:0]     r_window;

    logic [TIME_W-1:0]      r_now;
    logic [TIME_W-1:0]      r_run_start;
    logic [CNT_W-1:0]       r_count;
    logic [QUEUE_DEPTH-1:0] r_busy;
    logic [QUEUE_DEPTH-1:0] r_per;
    logic [SLOT_W-1:0]      r_slot;
    logic [TIME_W-1:0]      r_rel;
    logic [CNT_W-1:0]       r_pos;
    logic                   r_found;

    logic [SLOT_W-1:0]      r_ord_q;
    logic [TIME_W-1:0]      r_due_q;
    logic [TAG_W-1:0]       r_tag_q;
    logic [DELAY_W-1:0]     r_per_q;

    t_status                r_status;
    logic [SLOT_W-1:0]      r_handle;
    logic [TAG_W-1:0]       r_res_tag;

    logic [SLOT_W-1:0]      ord_mem [QUEUE_DEPTH];
    logic [TIME_W-1:0]      due_mem [QUEUE_DEPTH];
    logic [TAG_W-1:0]       tag_mem [QUEUE_DEPTH];
    logic [DELAY_W-1:0]     per_mem [QUEUE_DEPTH];

    logic                   has_free;
    logic [SLOT_W-1:0]      free_idx;
    logic                   ord_we;
    logic [SLOT_W-1:0]      ord_wa;
    logic [SLOT_W-1:0]      ord_wd;
    logic                   ord_re;
    logic [SLOT_W-1:0]      ord_ra;
    logic                   due_we;
    logic [SLOT_W-1:0]      due_wa;
    logic [TIME_W-1:0]      due_wd;
    logic                   slot_re;
    logic [CNT_W-1:0]       pos_m1;

    // lowest free slot
    always_comb begin
        has_free = 1'b0;
        free_idx = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                has_free = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign pos_m1 = r_pos - CNT_W'(1);

    always_comb begin
        ord_we  = 1'b0;
        ord_wa  = r_pos[SLOT_W-1:0];
        ord_wd  = r_ord_q;
        ord_re  = 1'b0;
        ord_ra  = r_pos[SLOT_W-1:0];
        due_we  = 1'b0;
        due_wa  = r_slot;
        due_wd  = r_now + {{(TIME_W-DELAY_W){1'b0}}, r_per_q};
        slot_re = 1'b0;
        unique case (i_cmd.op)
            DP_INS_ALLOC: begin
                due_we = 1'b1;
                due_wa = free_idx;
                due_wd = r_now + {{(TIME_W-DELAY_W){1'b0}}, r_delay};
            end
            DP_REARM: due_we = 1'b1;
            DP_HEAD_READ: begin
                ord_re = 1'b1;
                ord_ra = '0;
            end
            DP_ENQ_READ_ORD: begin
                ord_re = 1'b1;
                ord_ra = pos_m1[SLOT_W-1:0];
            end
            DP_RM_READ: ord_re = 1'b1;
            DP_ENQ_SHIFT: ord_we = 1'b1;
            DP_ENQ_PUT: begin
                ord_we = 1'b1;
                ord_wd = r_slot;
            end
            DP_RM_CHECK: begin
                ord_we = r_found;
                ord_wa = pos_m1[SLOT_W-1:0];
            end
            DP_ENQ_READ_DUE, DP_POP_READ: slot_re = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ord_we) ord_mem[ord_wa] <= ord_wd;
        if (ord_re) r_ord_q <= ord_mem[ord_ra];
    end

    always_ff @(posedge i_clk) begin
        if (due_we) due_mem[due_wa] <= due_wd;
        if (slot_re) r_due_q <= due_mem[r_ord_q];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_INS_ALLOC) begin
            tag_mem[free_idx] <= r_in_tag;
            per_mem[free_idx] <= r_delay;
        end
        if (i_cmd.op == DP_POP_READ) begin
            r_tag_q <= tag_mem[r_ord_q];
            r_per_q <= per_mem[r_ord_q];
        end
    end

    // request fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_LATCH) begin
            r_op        <= i_op;
            r_delay     <= i_wait_ns;
            r_in_tag    <= i_event_tag;
            r_in_per    <= i_periodic;
            r_in_handle <= i_cancel_handle;
            r_window    <= i_window_ns;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now       <= '0;
            r_run_start <= '0;
            r_count     <= '0;
            r_busy      <= '0;
            r_per       <= '0;
        end else begin
            unique case (i_cmd.op)
                DP_LATCH: begin
                    if (t_op'(i_op) == OP_POP && i_new_run) r_run_start <= r_now;
                end
                DP_INS_ALLOC: begin
                    r_busy[free_idx] <= 1'b1;
                    r_per[free_idx]  <= r_in_per;
                end
                DP_CANCEL_START: begin
                    r_busy[r_in_handle] <= 1'b0;
                    r_per[r_in_handle]  <= 1'b0;
                end
                DP_ENQ_PUT:    r_count <= r_count + CNT_W'(1);
                DP_RM_END:     r_count <= r_count - CNT_W'(1);
                DP_POP_ACCEPT: r_now <= r_due_q;
                default: ;
            endcase
            if (i_cmd.free_slot) begin
                r_busy[r_slot] <= 1'b0;
                r_per[r_slot]  <= 1'b0;
            end
        end
    end

    // work registers and result
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LATCH: begin
                r_status  <= ST_OK;
                r_handle  <= '0;
                r_res_tag <= '0;
            end
            DP_SET_STATUS: r_status <= i_cmd.code;
            DP_INS_ALLOC: begin
                r_slot   <= free_idx;
                r_handle <= free_idx;
                r_rel    <= {{(TIME_W-DELAY_W){1'b0}}, r_delay};
                r_pos    <= r_count;
            end
            DP_CANCEL_START: begin
                r_slot  <= r_in_handle;
                r_pos   <= '0;
                r_found <= 1'b0;
            end
            DP_ENQ_SHIFT: r_pos <= pos_m1;
            DP_RM_CHECK: begin
                if (!r_found && r_ord_q == r_slot) r_found <= 1'b1;
                r_pos <= r_pos + CNT_W'(1);
            end
            DP_POP_READ: r_slot <= r_ord_q;
            DP_POP_ACCEPT: begin
                r_handle  <= r_slot;
                r_res_tag <= r_tag_q;
                r_pos     <= '0;
                r_found   <= 1'b0;
            end
            DP_REARM: begin
                r_rel <= {{(TIME_W-DELAY_W){1'b0}}, r_per_q};
                r_pos <= r_count;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_sts.op            = t_op'(r_op);
        o_sts.full          = (r_count >= CNT_W'(QUEUE_DEPTH)) || !has_free;
        o_sts.handle_busy   = r_busy[r_in_handle];
        o_sts.empty         = (r_count == '0);
        o_sts.pos_zero      = (r_pos == '0);
        o_sts.pos_at_count  = (r_pos == r_count);
        o_sts.enq_stop      = ((r_due_q - r_now) <= r_rel);
        o_sts.beyond        = ((r_due_q - r_run_start) >
                               {{(TIME_W-DELAY_W){1'b0}}, r_window});
        o_sts.slot_periodic = r_per[r_slot];
    end

    assign o_status        = r_status;
    assign o_slot_handle   = r_handle;
    assign o_delivered_tag = r_res_tag;
    assign o_current_time  = r_now;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("pending count above depth");
    a_busy_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == DP_LATCH |-> $countones(r_busy) == 32'(r_count))
        else $error("busy slots differ from pending count");
    a_put_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == DP_ENQ_PUT |-> r_count < CNT_W'(QUEUE_DEPTH))
        else $error("enqueue into a full order list");
`endif

endmodule

/* hw/rtl/teq_ctrl.sv */
// controller state machine of the timed event queue
`timescale 1ns / 1ps
module teq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output logic             o_done,
    output teq_pkg::t_dp_cmd o_cmd,
    input  teq_pkg::t_dp_sts i_sts
);
    import teq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start) n_state = S_DECODE;
            S_DECODE: begin
                unique case (i_sts.op)
                    OP_INSERT: n_state = i_sts.full ? S_DONE : S_ENQ_TEST;
                    OP_CANCEL: n_state = i_sts.handle_busy ? S_RM_RD : S_DONE;
                    OP_POP:    n_state = i_sts.empty ? S_DONE : S_POP_RD1;
                    OP_NOP:    n_state = S_DONE;
                endcase
            end
            S_ENQ_TEST: n_state = i_sts.pos_zero ? S_DONE : S_ENQ_RD1;
            S_ENQ_RD1:  n_state = S_ENQ_RD2;
            S_ENQ_RD2:  n_state = i_sts.enq_stop ? S_DONE : S_ENQ_TEST;
            S_RM_RD: begin
                if (i_sts.pos_at_count) begin
                    n_state = (i_sts.op == OP_POP) ? S_POP_TAIL : S_DONE;
                end else begin
                    n_state = S_RM_CHK;
                end
            end
            S_RM_CHK:   n_state = S_RM_RD;
            S_POP_RD1:  n_state = S_POP_RD2;
            S_POP_RD2:  n_state = i_sts.beyond ? S_DONE : S_RM_RD;
            S_POP_TAIL: n_state = i_sts.slot_periodic ? S_ENQ_TEST : S_DONE;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op        = DP_NOP;
        o_cmd.code      = ST_OK;
        o_cmd.free_slot = 1'b0;
        unique case (r_state)
            S_IDLE: if (start) o_cmd.op = DP_LATCH;
            S_DECODE: begin
                unique case (i_sts.op)
                    OP_INSERT: begin
                        if (i_sts.full) begin
                            o_cmd.op   = DP_SET_STATUS;
                            o_cmd.code = ST_FULL;
                        end else begin
                            o_cmd.op = DP_INS_ALLOC;
                        end
                    end
                    OP_CANCEL: begin
                        if (i_sts.handle_busy) begin
                            o_cmd.op = DP_CANCEL_START;
                        end else begin
                            o_cmd.op   = DP_SET_STATUS;
                            o_cmd.code = ST_NOT_PENDING;
                        end
                    end
                    OP_POP: begin
                        if (i_sts.empty) begin
                            o_cmd.op   = DP_SET_STATUS;
                            o_cmd.code = ST_EMPTY;
                        end else begin
                            o_cmd.op = DP_HEAD_READ;
                        end
                    end
                    OP_NOP: o_cmd.op = DP_NOP;
                endcase
            end
            S_ENQ_TEST: o_cmd.op = i_sts.pos_zero ? DP_ENQ_PUT : DP_ENQ_READ_ORD;
            S_ENQ_RD1:  o_cmd.op = DP_ENQ_READ_DUE;
            S_ENQ_RD2:  o_cmd.op = i_sts.enq_stop ? DP_ENQ_PUT : DP_ENQ_SHIFT;
            S_RM_RD:    o_cmd.op = i_sts.pos_at_count ? DP_RM_END : DP_RM_READ;
            S_RM_CHK:   o_cmd.op = DP_RM_CHECK;
            S_POP_RD1:  o_cmd.op = DP_POP_READ;
            S_POP_RD2: begin
                if (i_sts.beyond) begin
                    o_cmd.op   = DP_SET_STATUS;
                    o_cmd.code = ST_LIMIT;
                end else begin
                    o_cmd.op = DP_POP_ACCEPT;
                end
            end
            S_POP_TAIL: begin
                if (i_sts.slot_periodic) begin
                    o_cmd.op = DP_REARM;
                end else begin
                    o_cmd.free_slot = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

`ifndef NO_ASSERTIONS
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("busy after result strobe");
    a_start_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> r_state == S_DECODE)
        else $error("request not taken");
    a_latch_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.op == DP_LATCH |-> r_state == S_IDLE)
        else $error("request latched while busy");
`endif

endmodule

/* hw/rtl/timed_event_queue.sv */
// Insert places the event behind every queued event due no later, walking the order list
// from its tail, or reports full; cancel walks the list to remove the event, or reports
// not pending; pop reports empty or beyond the window, else removes the head event and
// re-inserts it if periodic. The order list is walked one entry per step
// One request at a time: a new start is taken from the cycle after o_done, never stalled
// Reset: synchronous active-low; clears time, run start, pending count and slot flags
`timescale 1ns / 1ps
module timed_event_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [teq_pkg::OP_W-1:0]      i_op,
    input  logic [teq_pkg::DELAY_W-1:0]   i_wait_ns,
    input  logic [teq_pkg::TAG_W-1:0]     i_event_tag,
    input  logic                          i_periodic,
    input  logic [teq_pkg::SLOT_W-1:0]    i_cancel_handle,
    input  logic [teq_pkg::DELAY_W-1:0]   i_window_ns,
    input  logic                          i_new_run,
    output logic                          o_done,
    output logic [teq_pkg::STATUS_W-1:0]  o_status,
    output logic [teq_pkg::SLOT_W-1:0]    o_slot_handle,
    output logic [teq_pkg::TAG_W-1:0]     o_delivered_tag,
    output logic [teq_pkg::TIME_W-1:0]    o_current_time
);
    import teq_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    teq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    teq_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_op            (i_op),
        .i_wait_ns       (i_wait_ns),
        .i_event_tag     (i_event_tag),
        .i_periodic      (i_periodic),
        .i_cancel_handle (i_cancel_handle),
        .i_window_ns     (i_window_ns),
        .i_new_run       (i_new_run),
        .o_status        (o_status),
        .o_slot_handle   (o_slot_handle),
        .o_delivered_tag (o_delivered_tag),
        .o_current_time  (o_current_time)
    );

endmodule

/* test/teq_checker.sv */
// request monitor, timed event queue predictor and result comparison
`timescale 1ns / 1ps
module teq_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [teq_pkg::OP_W-1:0]      i_op,
    input  logic [teq_pkg::DELAY_W-1:0]   i_wait_ns,
    input  logic [teq_pkg::TAG_W-1:0]     i_event_tag,
    input  logic                          i_periodic,
    input  logic [teq_pkg::SLOT_W-1:0]    i_cancel_handle,
    input  logic [teq_pkg::DELAY_W-1:0]   i_window_ns,
    input  logic                          i_new_run,
    input  logic                          i_done,
    input  logic [teq_pkg::STATUS_W-1:0]  i_status,
    input  logic [teq_pkg::SLOT_W-1:0]    i_slot_handle,
    input  logic [teq_pkg::TAG_W-1:0]     i_delivered_tag,
    input  logic [teq_pkg::TIME_W-1:0]    i_current_time,
    output int                            o_fail_count,
    output int                            o_outstanding
);
    import teq_pkg::*;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  handle;
        logic [TAG_W-1:0]   tag;
        logic [TIME_W-1:0]  now;
    } t_outcome;

    logic [TIME_W-1:0]  now_ns;
    logic [TIME_W-1:0]  run_base;
    logic [SLOT_W-1:0]  order [QUEUE_DEPTH+1];
    int                 n_pending;
    logic [TIME_W-1:0]  due_ns [QUEUE_DEPTH];
    logic [TAG_W-1:0]   tag_of [QUEUE_DEPTH];
    logic [DELAY_W-1:0] period_of [QUEUE_DEPTH];
    logic               in_use [QUEUE_DEPTH];
    logic               rearm [QUEUE_DEPTH];
    t_outcome           expected_q [$];

    // sort slot in behind every event due no later
    function automatic void queue_slot(input int s);
        logic [TIME_W-1:0] rel;
        int p;
        rel = due_ns[s] - now_ns;
        p = 0;
        while (p < n_pending && (due_ns[order[p]] - now_ns) <= rel) p++;
        for (int k = n_pending; k > p; k--) order[k] = order[k-1];
        order[p] = s[SLOT_W-1:0];
        n_pending++;
    endfunction

    function automatic void drop_at(input int p);
        for (int k = p; k < n_pending - 1; k++) order[k] = order[k+1];
        n_pending--;
    endfunction

    function automatic t_outcome schedule_step(input t_op op);
        t_outcome r;
        int s;
        int p;
        r = '{ST_OK, '0, '0, '0};
        case (op)
            OP_INSERT: begin
                s = 0;
                while (s < QUEUE_DEPTH && in_use[s]) s++;
                if (n_pending >= QUEUE_DEPTH || s >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    due_ns[s] = now_ns + TIME_W'(i_wait_ns);
                    tag_of[s] = i_event_tag;
                    period_of[s] = i_wait_ns;
                    in_use[s] = 1'b1;
                    rearm[s] = i_periodic;
                    queue_slot(s);
                    r.handle = s[SLOT_W-1:0];
                end
            end
            OP_CANCEL: begin
                if (!in_use[i_cancel_handle]) begin
                    r.status = ST_NOT_PENDING;
                end else begin
                    p = 0;
                    while (p < n_pending && order[p] != i_cancel_handle) p++;
                    if (p < n_pending) drop_at(p);
                    in_use[i_cancel_handle] = 1'b0;
                    rearm[i_cancel_handle] = 1'b0;
                end
            end
            OP_POP: begin
                if (i_new_run) run_base = now_ns;
                if (n_pending == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    s = order[0];
                    if ((due_ns[s] - run_base) > TIME_W'(i_window_ns)) begin
                        r.status = ST_LIMIT;
                    end else begin
                        drop_at(0);
                        now_ns = due_ns[s];
                        r.handle = s[SLOT_W-1:0];
                        r.tag = tag_of[s];
                        if (rearm[s]) begin
                            due_ns[s] = now_ns + TIME_W'(period_of[s]);
                            queue_slot(s);
                        end else begin
                            in_use[s] = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.now = now_ns;
        return r;
    endfunction

    assign o_outstanding = expected_q.size();

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            now_ns = '0;
            run_base = '0;
            n_pending = 0;
            for (int k = 0; k < QUEUE_DEPTH; k++) begin
                in_use[k] = 1'b0;
                rearm[k] = 1'b0;
            end
            expected_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_done) begin
                got = '{t_status'(i_status), i_slot_handle, i_delivered_tag, i_current_time};
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result: status %0d handle %0d tag %h time %h",
                                 i_status, i_slot_handle, i_delivered_tag, i_current_time);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display({"result mismatch: expected status %0d handle %0d tag %h",
                                      " time %h, got status %0d handle %0d tag %h time %h"},
                                     want.status, want.handle, want.tag, want.now,
                                     i_status, i_slot_handle, i_delivered_tag,
                                     i_current_time);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy)
                expected_q.push_back(schedule_step(t_op'(i_op)));
        end
    end

endmodule

/* test/tb.sv */
// testbench top: clock, reset, request stimulus, watchdog and verdict
`timescale 1ns / 1ps
module tb;
    import teq_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam logic [DELAY_W-1:0] ALL_ONES = '1;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     op = OP_NOP;
    logic [DELAY_W-1:0]  wait_ns = '0;
    logic [TAG_W-1:0]    event_tag = '0;
    logic                periodic = 1'b0;
    logic [SLOT_W-1:0]   cancel_handle = '0;
    logic [DELAY_W-1:0]  window_ns = '0;
    logic                new_run = 1'b0;
    logic                o_done;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_slot_handle;
    logic [TAG_W-1:0]    o_delivered_tag;
    logic [TIME_W-1:0]   o_current_time;
    int                  fail_count;
    int                  outstanding;
    int                  quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    timed_event_queue uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(op), .i_wait_ns(wait_ns), .i_event_tag(event_tag),
        .i_periodic(periodic), .i_cancel_handle(cancel_handle),
        .i_window_ns(window_ns), .i_new_run(new_run), .o_done(o_done),
        .o_status(o_status), .o_slot_handle(o_slot_handle),
        .o_delivered_tag(o_delivered_tag), .o_current_time(o_current_time)
    );

    teq_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_op(op), .i_wait_ns(wait_ns), .i_event_tag(event_tag),
        .i_periodic(periodic), .i_cancel_handle(cancel_handle),
        .i_window_ns(window_ns), .i_new_run(new_run), .i_done(o_done),
        .i_status(o_status), .i_slot_handle(o_slot_handle),
        .i_delivered_tag(o_delivered_tag), .i_current_time(o_current_time),
        .o_fail_count(fail_count), .o_outstanding(outstanding)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // one request, held until taken, then start drops
    task automatic send_request(input t_op o, input logic [DELAY_W-1:0] d,
                                input logic [TAG_W-1:0] t, input logic per,
                                input logic [SLOT_W-1:0] h,
                                input logic [DELAY_W-1:0] w, input logic nr);
        while (busy) @(negedge i_clk);
        op = o;
        wait_ns = d;
        event_tag = t;
        periodic = per;
        cancel_handle = h;
        window_ns = w;
        new_run = nr;
        start = 1'b1;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    function automatic logic [DELAY_W-1:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 75) return DELAY_W'($urandom_range(1, 2000));
        if (r < 85) return ALL_ONES;
        return DELAY_W'({$urandom, $urandom});
    endfunction

    function automatic logic [DELAY_W-1:0] pick_window();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return ALL_ONES;
        if (r < 70) return '0;
        if (r < 85) return DELAY_W'($urandom_range(0, 5000));
        return DELAY_W'({$urandom, $urandom});
    endfunction

    initial begin
        int burst;
        int r;
        int ins_pct;
        int pop_pct;
        int settle;
        t_op o;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed corner cases
        send_request(OP_POP, '0, '0, 1'b0, '0, ALL_ONES, 1'b1);
        send_request(OP_CANCEL, '0, '0, 1'b0, 6'd63, '0, 1'b0);
        send_request(OP_NOP, ALL_ONES, 16'hffff, 1'b1, 6'd63, ALL_ONES, 1'b1);
        send_request(OP_INSERT, '0, 16'h0000, 1'b0, '0, '0, 1'b0);
        send_request(OP_INSERT, ALL_ONES, 16'hffff, 1'b0, '0, '0, 1'b0);
        send_request(OP_INSERT, 48'd100, 16'h1234, 1'b1, '0, '0, 1'b0);
        send_request(OP_INSERT, '0, 16'h00aa, 1'b1, '0, '0, 1'b0);
        send_request(OP_INSERT, 48'd100, 16'h5555, 1'b0, '0, '0, 1'b0);
        send_request(OP_POP, '0, '0, 1'b0, '0, '0, 1'b1);
        send_request(OP_POP, '0, '0, 1'b0, '0, ALL_ONES, 1'b0);
        send_request(OP_POP, '0, '0, 1'b0, '0, ALL_ONES, 1'b0);
        send_request(OP_POP, '0, '0, 1'b0, '0, 48'd50, 1'b1);
        send_request(OP_POP, '0, '0, 1'b0, '0, 48'd100, 1'b0);
        send_request(OP_POP, '0, '0, 1'b0, '0, ALL_ONES, 1'b0);
        send_request(OP_CANCEL, '0, '0, 1'b0, 6'd3, '0, 1'b0);
        send_request(OP_CANCEL, '0, '0, 1'b0, 6'd2, '0, 1'b0);
        send_request(OP_CANCEL, '0, '0, 1'b0, 6'd2, '0, 1'b0);
        send_request(OP_POP, '0, '0, 1'b0, '0, ALL_ONES, 1'b1);
        send_request(OP_POP, '0, '0, 1'b0, '0, ALL_ONES, 1'b1);

        // random phases: fill, drain, mixed
        ins_pct = 50;
        pop_pct = 30;
        for (int n = 0; n < 700; n++) begin
            if (n % 60 == 0) begin
                r = $urandom_range(0, 2);
                ins_pct = (r == 0) ? 88 : (r == 1) ? 15 : 45;
                pop_pct = (r == 0) ? 6 : (r == 1) ? 75 : 35;
            end
            r = $urandom_range(0, 99);
            if (r < ins_pct) o = OP_INSERT;
            else if (r < ins_pct + pop_pct) o = OP_POP;
            else if (r < 97) o = OP_CANCEL;
            else o = OP_NOP;
            send_request(o, pick_delay(), TAG_W'($urandom), $urandom_range(0, 3) == 0,
                         SLOT_W'($urandom), pick_window(), $urandom_range(0, 3) == 0);
            if (burst > 0) begin
                burst--;
            end else begin
                burst = $urandom_range(0, 12);
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end
        end

        settle = 0;
        while (outstanding != 0 && settle < STALL_LIMIT) begin
            @(negedge i_clk);
            settle++;
        end
        repeat (400) @(negedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
